FILE: rtl/ray_annulus_intersection_macros.svh
// Assertion macros shared by the checker of the ray/annulus block.
// Depends on nothing; expects clk and rst_n in the scope of use.
`ifndef RAY_ANNULUS_INTERSECTION_MACROS_SVH
`define RAY_ANNULUS_INTERSECTION_MACROS_SVH

// Implication in the same cycle, off while in reset.
`define RAI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication into the next cycle, checked during reset too.
`define RAI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/rai_pkg.sv
// Shared constants and register codes for the ray/annulus intersection block.
// Depends on nothing.
package rai_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int CFG_IDX_W       = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORMAL_X     = 3'd0,
    REG_NORMAL_Y     = 3'd1,
    REG_NORMAL_Z     = 3'd2,
    REG_PLANE_OFFSET = 3'd3,
    REG_CENTER_X     = 3'd4,
    REG_CENTER_Y     = 3'd5,
    REG_CENTER_Z     = 3'd6,
    REG_RADIUS_PAIR  = 3'd7
  } cfg_reg_t;

endpackage

FILE: rtl/rai_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
// Depends on nothing; instantiated by ray_annulus_intersection.
module rai_div #(
  parameter int XW  = 114,
  parameter int DW  = 66,
  parameter int QW  = 31,
  parameter int SBW = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [XW-1:0]  in_rem,
  input  logic [DW-1:0]  in_dvs,
  input  logic [SBW-1:0] in_sb,
  output logic           out_valid,
  output logic [QW-1:0]  out_q,
  output logic [SBW-1:0] out_sb
);

  logic [XW-1:0]  rem_r [QW];
  logic [DW-1:0]  dvs_r [QW];
  logic [QW-1:0]  q_r   [QW];
  logic [SBW-1:0] sb_r  [QW];
  logic           v_r   [QW];

  genvar k;
  generate
    for (k = 0; k < QW; k++) begin : g_stage
      logic [XW-1:0]  rem_i;
      logic [DW-1:0]  dvs_i;
      logic [QW-1:0]  q_i;
      logic [SBW-1:0] sb_i;
      logic           v_i;
      logic [XW-1:0]  ds;
      logic [XW-1:0]  rem_nxt;
      logic [QW-1:0]  q_nxt;

      if (k == 0) begin : g_first
        assign rem_i = in_rem;
        assign dvs_i = in_dvs;
        assign q_i   = '0;
        assign sb_i  = in_sb;
        assign v_i   = in_valid;
      end else begin : g_next
        assign rem_i = rem_r[k-1];
        assign dvs_i = dvs_r[k-1];
        assign q_i   = q_r[k-1];
        assign sb_i  = sb_r[k-1];
        assign v_i   = v_r[k-1];
      end

      // trial subtract of the divisor aligned to this quotient bit
      always_comb begin
        ds      = XW'(dvs_i) << (QW - 1 - k);
        rem_nxt = rem_i;
        q_nxt   = q_i;
        if (rem_i >= ds) begin
          rem_nxt           = rem_i - ds;
          q_nxt[QW - 1 - k] = 1'b1;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en) begin
          v_r[k] <= v_i;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= rem_nxt;
          dvs_r[k] <= dvs_i;
          q_r[k]   <= q_nxt;
          sb_r[k]  <= sb_i;
        end
      end
    end
  endgenerate

  assign out_valid = v_r[QW-1];
  assign out_q     = q_r[QW-1];
  assign out_sb    = sb_r[QW-1];

endmodule

FILE: rtl/ray_annulus_intersection.sv
// Channel | Dir | Contents
// in_     | in  | tdata: origin_x/y/z, dir_x/y/z (signed fixed point)
// out_    | out | tdata: hit, distance_t, point_x/y/z
// cfg_    | in  | cfg_index selects register, cfg_data carries the value
//
// One ray per cycle while the output is not stalled; the divider
// resolves one quotient bit per stage.
// Reset is synchronous, active low; registers return to normal (0,0,1.0).
// The pipeline holds as a whole while the output register is stalled and
// its last stage is full; an empty last stage lets every stage advance.
// Depends on rai_pkg and rai_div.
module ray_annulus_intersection #(
  parameter int COORD_WIDTH = rai_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rai_pkg::FRAC_BITS_DEF,
  localparam int IN_TW  = ((6 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_TW = ((4 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic [IN_TW-1:0]             in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // hit, distance_t, point_x, point_y, point_z
  output logic [OUT_TW-1:0]            out_tdata,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rai_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [2*COORD_WIDTH-1:0]     cfg_data
);

  localparam int W   = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W;
  localparam int DW  = 2 * W + 2;
  localparam int NW  = 2 * W + 3;
  localparam int XW  = 3 * W + F + 2;
  localparam int QW  = W - 1;
  localparam int SW  = 2 * W + 2;
  localparam int SBW = 6 * W + 2;
  localparam logic signed [PW:0] PMAX = {{(PW - W + 2){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [PW:0] PMIN = ~PMAX;

  // configuration registers
  logic signed [W-1:0] nrm_r [3];
  logic signed [W-1:0] doff_r;
  logic signed [W-1:0] ctr_r [3];
  logic [W-1:0]        rin_r;
  logic [W-1:0]        rout_r;
  logic [PW-1:0]       r1sq_r;
  logic [PW-1:0]       r2sq_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nrm_r[0] <= '0;
      nrm_r[1] <= '0;
      nrm_r[2] <= W'(1) << F;
      doff_r   <= '0;
      ctr_r[0] <= '0;
      ctr_r[1] <= '0;
      ctr_r[2] <= '0;
      rin_r    <= '0;
      rout_r   <= '0;
    end else if (cfg_valid) begin
      case (rai_pkg::cfg_reg_t'(cfg_index))
        rai_pkg::REG_NORMAL_X:     nrm_r[0] <= cfg_data[W-1:0];
        rai_pkg::REG_NORMAL_Y:     nrm_r[1] <= cfg_data[W-1:0];
        rai_pkg::REG_NORMAL_Z:     nrm_r[2] <= cfg_data[W-1:0];
        rai_pkg::REG_PLANE_OFFSET: doff_r   <= cfg_data[W-1:0];
        rai_pkg::REG_CENTER_X:     ctr_r[0] <= cfg_data[W-1:0];
        rai_pkg::REG_CENTER_Y:     ctr_r[1] <= cfg_data[W-1:0];
        rai_pkg::REG_CENTER_Z:     ctr_r[2] <= cfg_data[W-1:0];
        rai_pkg::REG_RADIUS_PAIR: begin
          rin_r  <= cfg_data[W-1:0];
          rout_r <= cfg_data[2*W-1:W];
        end
        default: ;
      endcase
    end
  end

  // radius squares are registered and follow the registers in the next cycle
  always_ff @(posedge clk) begin
    r1sq_r <= PW'(rin_r) * PW'(rin_r);
    r2sq_r <= PW'(rout_r) * PW'(rout_r);
  end

  // pipeline control
  logic adv;
  logic vc_r;
  logic out_valid_r;

  assign adv       = !out_valid_r || out_tready || !vc_r;
  assign in_tready = adv;

  // stage 1: products of the normal with origin and direction
  logic signed [W-1:0]  o_in [3];
  logic signed [W-1:0]  d_in [3];
  logic                 v1_r;
  logic signed [PW-1:0] dn1_r [3];
  logic signed [PW-1:0] on1_r [3];
  logic signed [W-1:0]  o1_r [3];
  logic signed [W-1:0]  d1_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      o_in[i] = in_tdata[i*W +: W];
      d_in[i] = in_tdata[(3+i)*W +: W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dn1_r[i] <= nrm_r[i] * d_in[i];
        on1_r[i] <= nrm_r[i] * o_in[i];
        o1_r[i]  <= o_in[i];
        d1_r[i]  <= d_in[i];
      end
    end
  end

  // stage 2: dot product and negated plane distance
  logic                 v2_r;
  logic signed [DW-1:0] dot2_r;
  logic signed [NW-1:0] num2_r;
  logic signed [W-1:0]  o2_r [3];
  logic signed [W-1:0]  d2_r [3];
  logic signed [NW-1:0] ne;

  always_comb begin
    ne = (NW'(doff_r) <<< F) + NW'(on1_r[0]) + NW'(on1_r[1]) + NW'(on1_r[2]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dot2_r <= DW'(dn1_r[0]) + DW'(dn1_r[1]) + DW'(dn1_r[2]);
      num2_r <= -ne;
      o2_r   <= o1_r;
      d2_r   <= d1_r;
    end
  end

  // stage 3: miss test, magnitudes, quotient overflow test
  logic                 v3_r;
  logic [XW-1:0]        rem3_r;
  logic [DW-1:0]        adot3_r;
  logic                 sat3_r;
  logic                 miss3_r;
  logic signed [W-1:0]  o3_r [3];
  logic signed [W-1:0]  d3_r [3];
  logic [NW-1:0]        anum;
  logic [DW-1:0]        adot;
  logic [XW-1:0]        nsh;
  logic                 miss3;

  always_comb begin
    anum  = num2_r[NW-1] ? NW'(-num2_r) : NW'(num2_r);
    adot  = dot2_r[DW-1] ? DW'(-dot2_r) : DW'(dot2_r);
    nsh   = XW'(anum) << F;
    miss3 = (dot2_r == '0) ||
            ((num2_r != '0) && (num2_r[NW-1] != dot2_r[DW-1]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem3_r  <= nsh;
      adot3_r <= adot;
      sat3_r  <= nsh >= (XW'(adot) << QW);
      miss3_r <= miss3;
      o3_r    <= o2_r;
      d3_r    <= d2_r;
    end
  end

  // divider stages carry origin, direction and flags alongside
  logic [SBW-1:0] sb3;
  logic [SBW-1:0] sbq;
  logic [QW-1:0]  qq;
  logic           vq;

  assign sb3 = {miss3_r, sat3_r, d3_r[2], d3_r[1], d3_r[0], o3_r[2], o3_r[1], o3_r[0]};

  rai_div #(
    .XW  (XW),
    .DW  (DW),
    .QW  (QW),
    .SBW (SBW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v3_r),
    .in_rem    (rem3_r),
    .in_dvs    (adot3_r),
    .in_sb     (sb3),
    .out_valid (vq),
    .out_q     (qq),
    .out_sb    (sbq)
  );

  // stage A: saturate t and scale the direction
  logic signed [W-1:0]  oq [3];
  logic signed [W-1:0]  dq [3];
  logic [QW-1:0]        tq;
  logic                 va_r;
  logic                 missa_r;
  logic [QW-1:0]        ta_r;
  logic signed [PW-1:0] pra_r [3];
  logic signed [W-1:0]  oa_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      oq[i] = sbq[i*W +: W];
      dq[i] = sbq[(3+i)*W +: W];
    end
    tq = sbq[6*W] ? {QW{1'b1}} : qq;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      missa_r <= sbq[6*W+1];
      ta_r    <= tq;
      for (int i = 0; i < 3; i++) begin
        pra_r[i] <= $signed({1'b0, tq}) * dq[i];
        oa_r[i]  <= oq[i];
      end
    end
  end

  // stage B: hit point with saturation, distance from the center
  logic                 vb_r;
  logic                 missb_r;
  logic [QW-1:0]        tb_r;
  logic signed [W-1:0]  pb_r [3];
  logic [W:0]           magb_r [3];
  logic signed [W-1:0]  pb [3];
  logic [W:0]           magb [3];
  logic signed [PW:0]   sumb;
  logic signed [W:0]    diffb;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sumb = (PW+1)'(pra_r[i] >>> F) + (PW+1)'(oa_r[i]);
      if (sumb > PMAX) begin
        pb[i] = PMAX[W-1:0];
      end else if (sumb < PMIN) begin
        pb[i] = PMIN[W-1:0];
      end else begin
        pb[i] = sumb[W-1:0];
      end
      diffb   = (W+1)'(pb[i]) - (W+1)'(ctr_r[i]);
      magb[i] = diffb[W] ? (W+1)'(-diffb) : (W+1)'(diffb);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      missb_r <= missa_r;
      tb_r    <= ta_r;
      pb_r    <= pb;
      magb_r  <= magb;
    end
  end

  // stage C: squares
  logic          missc_r;
  logic [QW-1:0] tc_r;
  logic signed [W-1:0] pc_r [3];
  logic [SW-1:0] sqc_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      missc_r <= missb_r;
      tc_r    <= tb_r;
      pc_r    <= pb_r;
      for (int i = 0; i < 3; i++) begin
        sqc_r[i] <= SW'(magb_r[i]) * SW'(magb_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      va_r <= vq;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  // output register: sum, range test, zero fields on a miss
  logic [SW+1:0]       dist_sq;
  logic                hitc;
  logic                hit_r;
  logic [QW-1:0]       t_r;
  logic signed [W-1:0] pt_r [3];

  always_comb begin
    dist_sq = (SW+2)'(sqc_r[0]) + (SW+2)'(sqc_r[1]) + (SW+2)'(sqc_r[2]);
    hitc = !missc_r && ((SW+2)'(r1sq_r) <= dist_sq) && (dist_sq <= (SW+2)'(r2sq_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      hit_r <= hitc;
      t_r   <= hitc ? tc_r : '0;
      for (int i = 0; i < 3; i++) begin
        pt_r[i] <= hitc ? pc_r[i] : '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TW'({pt_r[2], pt_r[1], pt_r[0], t_r, hit_r});

endmodule

FILE: rtl/rai_checker.sv
// Port-level checks for ray_annulus_intersection, bound to the top level.
// Depends on ray_annulus_intersection_macros.svh.
`include "ray_annulus_intersection_macros.svh"

module rai_checker #(
  parameter int COORD_WIDTH = 32,
  parameter int OUT_TW      = 128
) (
  input logic              clk,
  input logic              rst_n,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_TW-1:0] out_tdata
);

  // hold a stalled transfer
  `RAI_ASSERT_IMP(a_out_hold, $past(out_tvalid && !out_tready) && $past(rst_n), out_tvalid && $stable(out_tdata), "stalled result changed")

  // a miss carries all-zero fields
  `RAI_ASSERT_IMP(a_miss_zero, out_tvalid && !out_tdata[0], out_tdata[4*COORD_WIDTH-1:1] == '0, "miss with nonzero fields")

  // no result right after reset
  `RAI_ASSERT_NXT(a_reset_idle, !rst_n, !out_tvalid, "result valid after reset")

endmodule

bind ray_annulus_intersection rai_checker #(
  .COORD_WIDTH (COORD_WIDTH),
  .OUT_TW      (OUT_TW)
) u_rai_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: tb/tb.sv
// Self-checking bench for ray_annulus_intersection: directed rays, then random
// streams under several disk setups, with bursty input and stalling output.
// Depends on rai_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;

  localparam logic signed [31:0] ONE   = 32'sh0001_0000;
  localparam logic signed [31:0] M_ONE = -32'sh0001_0000;
  localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S_MIN = -32'sh7FFF_FFFF - 1;
  localparam int WDOG_LIMIT = 4000;

  typedef struct packed {
    logic signed [31:0] dz, dy, dx, oz, oy, ox;
  } ray_t;

  typedef struct packed {
    logic [31:0] pz, py, px;
    logic [30:0] t;
    logic        hit;
  } res_t;

  typedef struct {
    ray_t r;
    bit   known;
    res_t want;
  } row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [191:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [rai_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]  cfg_data = '0;

  // disk setup as the bench believes it
  logic signed [31:0] pl_n[3];
  logic signed [31:0] pl_off;
  logic signed [31:0] dk_c[3];
  logic [63:0]        dk_rad;

  res_t hit_q[$];
  int   errors = 0, n_rays = 0, n_res = 0, n_hits = 0;
  int   idle_cycles = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  int   rx_mode = 0;
  int   rx_tick = 0;

  ray_annulus_intersection DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic res_t trace_ray(ray_t r);
    logic signed [127:0] o[3], dv[3], nv[3], cv[3], p[3];
    logic signed [127:0] ne, dot, num, diff, tw;
    logic [127:0] an, ad, q, dist_sq, inn, outr;
    res_t res;
    o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
    dv[0] = r.dx; dv[1] = r.dy; dv[2] = r.dz;
    for (int i = 0; i < 3; i++) begin
      nv[i] = pl_n[i];
      cv[i] = dk_c[i];
    end
    ne = pl_off;
    ne = ne <<< 16;
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      dot = dot + nv[i] * dv[i];
      ne = ne + nv[i] * o[i];
    end
    num = -ne;
    res = '0;
    if (dot == 0) return res;
    if (num != 0 && num[127] != dot[127]) return res;
    an = num[127] ? -num : num;
    ad = dot[127] ? -dot : dot;
    q = (an << 16) / ad;
    if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
    tw = q;
    dist_sq = 0;
    for (int i = 0; i < 3; i++) begin
      p[i] = o[i] + ((tw * dv[i]) >>> 16);
      if (p[i] > 128'sh7FFF_FFFF) p[i] = 128'sh7FFF_FFFF;
      else if (p[i] < -128'sh8000_0000) p[i] = -128'sh8000_0000;
      diff = p[i] - cv[i];
      if (diff[127]) diff = -diff;
      dist_sq = dist_sq + diff * diff;
    end
    inn = dk_rad[31:0];
    outr = dk_rad[63:32];
    if (inn * inn <= dist_sq && dist_sq <= outr * outr) begin
      res.hit = 1'b1;
      res.t = q[30:0];
      res.px = p[0][31:0];
      res.py = p[1][31:0];
      res.pz = p[2][31:0];
    end
    return res;
  endfunction

  // full range or a small span around zero (+-16.0)
  function automatic logic signed [31:0] rnd_val(bit wide_rng);
    if (wide_rng) return $urandom;
    return $signed($urandom_range(0, 2097152)) - 32'sd1048576;
  endfunction

  function automatic ray_t rnd_ray(int wide_pct);
    ray_t r;
    r.ox = rnd_val($urandom_range(0, 99) < wide_pct);
    r.oy = rnd_val($urandom_range(0, 99) < wide_pct);
    r.oz = rnd_val($urandom_range(0, 99) < wide_pct);
    r.dx = rnd_val($urandom_range(0, 99) < wide_pct);
    r.dy = rnd_val($urandom_range(0, 99) < wide_pct);
    r.dz = rnd_val($urandom_range(0, 99) < wide_pct);
    return r;
  endfunction

  task automatic write_reg(rai_pkg::cfg_reg_t idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_disk(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                          logic [31:0] off, logic [31:0] cx, logic [31:0] cy,
                          logic [31:0] cz, logic [31:0] r_in, logic [31:0] r_out);
    while (hit_q.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
    write_reg(rai_pkg::REG_NORMAL_X, {32'h0, nx});
    write_reg(rai_pkg::REG_NORMAL_Y, {32'h0, ny});
    write_reg(rai_pkg::REG_NORMAL_Z, {32'h0, nz});
    write_reg(rai_pkg::REG_PLANE_OFFSET, {32'h0, off});
    write_reg(rai_pkg::REG_CENTER_X, {32'h0, cx});
    write_reg(rai_pkg::REG_CENTER_Y, {32'h0, cy});
    write_reg(rai_pkg::REG_CENTER_Z, {32'h0, cz});
    write_reg(rai_pkg::REG_RADIUS_PAIR, {r_out, r_in});
    // let the tracked copy take the last write before predicting
    @(posedge clk);
  endtask

  // queue the expectation, then hold valid until the transfer
  task automatic send_ray(ray_t r, bit known, res_t want);
    hit_q.push_back(known ? want : trace_ray(r));
    in_tvalid <= 1'b1;
    in_tdata  <= r;
    do @(posedge clk); while (!in_tready);
    n_rays++;
  endtask

  task automatic gap(int n);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic rand_phase(int count, int wide_pct, bit no_gaps);
    int burst;
    res_t none;
    none = '0;
    burst = 0;
    for (int k = 0; k < count; k++) begin
      send_ray(rnd_ray(wide_pct), 1'b0, none);
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if (!no_gaps) gap($urandom_range(0, 7));
      end else begin
        burst--;
      end
    end
    in_tvalid <= 1'b0;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // track configuration transfers, check result transfers, watch for a hang
  always @(posedge clk) begin
    res_t got, want;
    if (rst_n && cfg_valid && cfg_ready) begin
      case (rai_pkg::cfg_reg_t'(cfg_index))
        rai_pkg::REG_NORMAL_X:     pl_n[0] <= cfg_data[31:0];
        rai_pkg::REG_NORMAL_Y:     pl_n[1] <= cfg_data[31:0];
        rai_pkg::REG_NORMAL_Z:     pl_n[2] <= cfg_data[31:0];
        rai_pkg::REG_PLANE_OFFSET: pl_off  <= cfg_data[31:0];
        rai_pkg::REG_CENTER_X:     dk_c[0] <= cfg_data[31:0];
        rai_pkg::REG_CENTER_Y:     dk_c[1] <= cfg_data[31:0];
        rai_pkg::REG_CENTER_Z:     dk_c[2] <= cfg_data[31:0];
        rai_pkg::REG_RADIUS_PAIR:  dk_rad  <= cfg_data;
        default: ;
      endcase
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      n_res++;
      if (got.hit) n_hits++;
      if (hit_q.size() == 0) begin
        $display("%0t: result with nothing expected, actual %h", $time, got);
        errors++;
      end else begin
        want = hit_q.pop_front();
        check_field("hit", {31'h0, want.hit}, {31'h0, got.hit});
        check_field("distance_t", {1'b0, want.t}, {1'b0, got.t});
        check_field("point_x", want.px, got.px);
        check_field("point_y", want.py, got.py);
        check_field("point_z", want.pz, got.pz);
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WDOG_LIMIT);
      $display("[ray_annulus_intersection] ERROR");
      $finish;
    end
  end

  // output side: stall pattern redrawn on rx_tick, one long hold-off
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 128 == 0) rx_mode <= $urandom_range(0, 2);
    if (!hold_done && n_res >= 300) begin
      hold_left <= 400;
      hold_done <= 1'b1;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  initial begin
    row_t rows[$];
    res_t r_one, none;
    none = '0;
    r_one = '0;
    r_one.hit = 1'b1;
    r_one.t = 31'h1_0000;
    pl_n[0] = 0; pl_n[1] = 0; pl_n[2] = ONE;
    pl_off = 0;
    dk_c[0] = 0; dk_c[1] = 0; dk_c[2] = 0;
    dk_rad = '0;

    // after reset: plane z = 0, unit normal, zero radii
    // row fields: dz, dy, dx, oz, oy, ox
    rows.push_back('{'{M_ONE, 0, 0, ONE, 0, 0}, 1'b1, r_one});        // straight down
    rows.push_back('{'{ONE, 0, 0, ONE, 0, 0}, 1'b1, none});           // behind origin
    rows.push_back('{'{0, ONE, 0, ONE, 0, 0}, 1'b1, none});           // parallel
    rows.push_back('{'{0, 0, 0, ONE, 7, 5}, 1'b1, none});             // zero direction
    rows.push_back('{'{ONE, 0, 0, 0, 0, 0}, 1'b1, '0 | 1});           // origin on plane
    rows.push_back('{'{M_ONE, 0, 0, 0, 0, 0}, 1'b1, '0 | 1});         // touches at t 0
    rows.push_back('{'{ONE, 0, 0, 0, 5, 0}, 1'b1, none});             // on plane, off center
    rows.push_back('{'{-1, 0, 0, S_MAX, 0, 0}, 1'b0, none});          // saturated t
    rows.push_back('{'{S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN}, 1'b0, none});
    rows.push_back('{'{S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX}, 1'b0, none});
    rows.push_back('{'{S_MIN, 0, S_MAX, S_MIN, 0, S_MAX}, 1'b0, none});
    rows.push_back('{'{-1, -1, -1, 1, 1, 1}, 1'b0, none});

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) begin
      send_ray(rows[i].r, rows[i].known, rows[i].want);
      gap($urandom_range(0, 2));
    end
    in_tvalid <= 1'b0;

    // extreme normals and offset, ring with inner above outer: all miss
    set_disk(S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, 32'hFFFF_FFFF, 0);
    rand_phase(120, 60, 1'b0);
    // random plane, ring from zero out to the largest radius
    set_disk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             0, 32'hFFFF_FFFF);
    rand_phase(220, 50, 1'b1);
    // raised z plane with a modest ring, small rays give many hits
    set_disk(0, 0, ONE, 32'hFFFE_0000, 32'h0000_8000, 32'hFFFF_4000, 32'h0002_0000,
             32'h0002_0000, 32'h000C_0000);
    rand_phase(260, 3, 1'b0);
    // tilted plane, small values throughout
    set_disk(rnd_val(0), rnd_val(0), ONE, rnd_val(0), rnd_val(0), rnd_val(0),
             rnd_val(0), 32'h0001_0000, 32'h0010_0000);
    rand_phase(240, 10, 1'b0);
    // zero normal: every ray parallel
    set_disk(0, 0, 0, rnd_val(1), 0, 0, 0, 0, 32'hFFFF_FFFF);
    rand_phase(60, 50, 1'b0);
    // single point ring at the center of a z plane, random rays
    set_disk(0, 0, M_ONE, 0, 0, 0, 0, 0, 0);
    rand_phase(150, 20, 1'b0);

    while (hit_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Sent %0d rays over directed and six random disk setups;", n_rays);
    $display("checked %0d results, %0d of them hits.", n_res, n_hits);
    if (errors == 0 && hit_q.size() == 0)
      $display("[ray_annulus_intersection] OK");
    else
      $display("[ray_annulus_intersection] ERROR");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/rai_pkg.sv
rtl/rai_div.sv
rtl/ray_annulus_intersection.sv
rtl/rai_checker.sv
tb/tb.sv
